@@ hdl/ffd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg: shared types and constants of the fractional feedback delay
// Register map, gain and fraction formats and the control word of the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package ffd_pkg;

    localparam int DEF_BUFFER_DEPTH = 131072;
    localparam int DEF_SAMPLE_BITS  = 24;

    localparam int WHOLE_BITS = 17;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_BITS  = 17;

    // Q1.16 unity, in gain width, and half.
    localparam logic [GAIN_BITS-1:0] Q16_ONE  = 17'h10000;
    localparam int                   Q16_HALF = 32768;
    localparam int                   Q16_SHIFT = 16;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DELAY_WHOLE    = 2'd0,
        REG_DELAY_FRACTION = 2'd1,
        REG_FEEDBACK_GAIN  = 2'd2,
        REG_WET_LEVEL      = 2'd3
    } t_cfg_reg;

    // load: accumulator takes the product; accum: accumulator adds it.
    typedef struct packed {
        logic load;
        logic accum;
    } t_mac_ctrl;

endpackage

@@ hdl/ffd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ffd_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_mac: shared multiply-accumulate unit
// Registers sample times Q1.16 gain each cycle, then loads or adds the
// registered product into the accumulator under the sequencer's control.
// ----------------------------------------------------------------------------
module ffd_mac #(
    parameter int SAMPLE_BITS = ffd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic [ffd_pkg::GAIN_BITS-1:0] i_b,
    input  ffd_pkg::t_mac_ctrl            i_ctrl,
    output logic signed [SAMPLE_BITS+17:0] o_prod,
    output logic signed [SAMPLE_BITS+18:0] o_acc
);

    localparam int PW = SAMPLE_BITS + 18;
    localparam int AW = SAMPLE_BITS + 19;

    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [ffd_pkg::GAIN_BITS:0] w_b;

    always_comb begin
        w_b    = signed'({1'b0, i_b});
        n_prod = PW'(i_a) * PW'(w_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.load) begin
            r_acc <= AW'(r_prod);
        end else if (i_ctrl.accum) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

@@ hdl/ffd_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_mod: delay reduction modulo the store depth
// Multiplies the whole delay by a scaled reciprocal of the depth to get the
// quotient, then subtracts quotient times depth. Three pipelined steps,
// started by a write of the whole-delay register.
// ----------------------------------------------------------------------------
module ffd_mod #(
    parameter int BUFFER_DEPTH = ffd_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ffd_pkg::WHOLE_BITS-1:0]    i_value,
    output logic                              o_busy,
    output logic [$clog2(BUFFER_DEPTH)-1:0]   o_result
);

    localparam int ABITS = $clog2(BUFFER_DEPTH);
    localparam int VB    = ffd_pkg::WHOLE_BITS;
    localparam int SH    = VB + ABITS;
    localparam int MW    = VB + 2;
    localparam int PW    = VB + MW;
    localparam int CW    = 2;

    // Reciprocal of the depth scaled by 2^SH and rounded up. With a shift by
    // SH it yields the exact quotient for every value of VB bits.
    localparam longint RECIP = ((longint'(1) <<< SH) + longint'(BUFFER_DEPTH) - 1)
                               / longint'(BUFFER_DEPTH);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
    localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] STEPS   = 2'd3;

    logic [VB-1:0]    r_val;
    logic [PW-1:0]    r_prod;
    logic [VB-1:0]    r_quot;
    logic [ABITS-1:0] r_rem;
    logic [CW-1:0]    r_cnt;

    // Product, quotient and remainder advance as a pipeline; the remainder is
    // valid once the step count reaches zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= '0;
            r_prod <= '0;
            r_quot <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_val <= i_value;
            r_cnt <= STEPS;
        end else if (r_cnt != '0) begin
            r_prod <= PW'(r_val) * PW'(RECIP_M);
            r_quot <= VB'(r_prod >> SH);
            r_rem  <= ABITS'(r_val - VB'(PW'(r_quot) * DEPTH_P));
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_busy   = (r_cnt != '0);
    assign o_result = r_rem;

endmodule

@@ hdl/fractional_feedback_delay_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_feedback_delay_top: echo with fractional delay and feedback
// Circular delay store, linear interpolation between two taps, feedback
// into the store and a wet/dry mix, all on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel and leave on m_axis, one output beat
//   for every input beat. Registers must be written on the cfg channel only
//   while the block is idle, a rule that the block leaves to the user;
//   o_cfg_ready is always high. A new sample is accepted only once the
//   sequencer is back in idle, after the last one has passed all its steps:
//   two store reads through the single read port, five passes through the
//   shared multiplier and one store write.
//   A write of delay_whole starts a reduction of the delay modulo the store
//   depth; o_s_axis_tready stays low during it.
//   The output beat sits in a register; the next sample is accepted while it
//   waits, and the sequencer holds in its last step until that beat is taken.
//   Reset clears the registers and the write position. Store entries not yet
//   written since reset read as zero through a wrap flag, so no clearing
//   pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_top #(
    parameter int BUFFER_DEPTH = ffd_pkg::DEF_BUFFER_DEPTH,
    parameter int SAMPLE_BITS  = ffd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // tdata: sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        i_s_axis_tdata,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]        o_m_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ffd_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [ffd_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int TDW    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ABITS  = $clog2(BUFFER_DEPTH);
    localparam int AW     = SB + 19;
    localparam int RW     = SB + 3;
    localparam logic [ABITS:0]   DEPTH_X   = (ABITS + 1)'(BUFFER_DEPTH);
    localparam logic [ABITS-1:0] LAST_ADDR = ABITS'(BUFFER_DEPTH - 1);
    localparam logic signed [RW-1:0] SMAX = {4'b0000, {(SB-1){1'b1}}};
    localparam logic signed [RW-1:0] SMIN = {4'b1111, {(SB-1){1'b0}}};

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RA   = 10'b00_0000_0010,
        S_RB   = 10'b00_0000_0100,
        S_RC   = 10'b00_0000_1000,
        S_TAP  = 10'b00_0001_0000,
        S_FB   = 10'b00_0010_0000,
        S_WR   = 10'b00_0100_0000,
        S_MIX1 = 10'b00_1000_0000,
        S_MIX2 = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    function automatic logic signed [SB-1:0] f_sat(input logic signed [RW-1:0] v);
        logic signed [SB-1:0] res;
        if (v > SMAX) begin
            res = SMAX[SB-1:0];
        end else if (v < SMIN) begin
            res = SMIN[SB-1:0];
        end else begin
            res = v[SB-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic [ffd_pkg::WHOLE_BITS-1:0] r_delay_whole;
    logic [ffd_pkg::FRAC_BITS-1:0]  r_delay_fraction;
    logic [ffd_pkg::GAIN_BITS-1:0]  r_feedback_gain;
    logic [ffd_pkg::GAIN_BITS-1:0]  r_wet_level;

    // Sequencer and sample state
    t_state                r_state;
    t_state                n_state;
    logic [ABITS-1:0]      r_wp;
    logic                  r_wrapped;
    logic signed [SB-1:0]  r_x;
    logic signed [SB-1:0]  r_tap;
    logic [ABITS-1:0]      r_rd;
    logic [ABITS-1:0]      r_rd1;
    logic                  r_rd_ok;
    logic                  r_rd1_ok;
    logic signed [SB-1:0]  r_out;
    logic                  r_out_valid;

    // Combinational helpers
    logic                  w_cfg_we;
    logic                  w_accept;
    logic                  w_red_busy;
    logic [ABITS-1:0]      w_back;
    logic [ABITS-1:0]      w_rd;
    logic [ABITS-1:0]      w_rd1;
    logic [ffd_pkg::GAIN_BITS-1:0] w_fb;
    logic [ffd_pkg::GAIN_BITS-1:0] w_wet;
    logic [ffd_pkg::GAIN_BITS-1:0] w_dry;
    logic [ffd_pkg::GAIN_BITS-1:0] w_one_minus_frac;
    logic signed [SB-1:0]  w_mac_a;
    logic [ffd_pkg::GAIN_BITS-1:0] w_mac_b;
    ffd_pkg::t_mac_ctrl    w_mac_ctrl;
    logic signed [SB+17:0] w_prod;
    logic signed [AW-1:0]  w_acc;
    logic signed [RW-1:0]  w_rnd_acc;
    logic signed [RW-1:0]  w_rnd_prod;
    logic signed [SB-1:0]  w_tap_now;
    logic signed [SB-1:0]  w_stored;
    logic signed [SB-1:0]  w_mixed;
    logic [ABITS-1:0]      w_raddr;
    logic [SB-1:0]         w_rdata;
    logic                  w_we;
    logic                  w_out_free;

    assign o_cfg_ready     = 1'b1;
    assign w_cfg_we        = i_cfg_valid;
    assign o_s_axis_tready = (r_state == S_IDLE) && !w_red_busy;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_whole    <= '0;
            r_delay_fraction <= '0;
            r_feedback_gain  <= '0;
            r_wet_level      <= '0;
        end else if (w_cfg_we) begin
            unique case (ffd_pkg::t_cfg_reg'(i_cfg_index))
                ffd_pkg::REG_DELAY_WHOLE:    r_delay_whole    <= i_cfg_data;
                ffd_pkg::REG_DELAY_FRACTION: r_delay_fraction <= i_cfg_data[ffd_pkg::FRAC_BITS-1:0];
                ffd_pkg::REG_FEEDBACK_GAIN:  r_feedback_gain  <= i_cfg_data;
                ffd_pkg::REG_WET_LEVEL:      r_wet_level      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ffd_mod #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cfg_we && (ffd_pkg::t_cfg_reg'(i_cfg_index) == ffd_pkg::REG_DELAY_WHOLE)),
        .i_value  (i_cfg_data),
        .o_busy   (w_red_busy),
        .o_result (w_back)
    );

    // Gains above one saturate to one; dry share is one minus wet.
    always_comb begin
        w_fb  = r_feedback_gain[ffd_pkg::GAIN_BITS-1] ? ffd_pkg::Q16_ONE : r_feedback_gain;
        w_wet = r_wet_level[ffd_pkg::GAIN_BITS-1] ? ffd_pkg::Q16_ONE : r_wet_level;
        w_dry = ffd_pkg::Q16_ONE - w_wet;
        w_one_minus_frac = ffd_pkg::Q16_ONE - {1'b0, r_delay_fraction};
    end

    // Read taps, wrapping around the circular store.
    always_comb begin
        if (r_wp >= w_back) begin
            w_rd = r_wp - w_back;
        end else begin
            w_rd = ABITS'({1'b0, r_wp} + DEPTH_X - {1'b0, w_back});
        end
        w_rd1 = (w_rd == '0) ? LAST_ADDR : w_rd - 1'b1;
    end

    // Rounding half up of the products by Q1.16 gains.
    always_comb begin
        w_rnd_acc  = RW'((w_acc + AW'(ffd_pkg::Q16_HALF)) >>> ffd_pkg::Q16_SHIFT);
        w_rnd_prod = RW'((AW'(w_prod) + AW'(ffd_pkg::Q16_HALF)) >>> ffd_pkg::Q16_SHIFT);
        // The interpolated tap lies between its two samples, so it fits.
        w_tap_now  = w_rnd_acc[SB-1:0];
        w_stored   = f_sat(RW'(r_x) + w_rnd_prod);
        w_mixed    = f_sat(w_rnd_acc);
    end

    always_comb begin
        w_mac_a    = r_x;
        w_mac_b    = '0;
        w_mac_ctrl = '0;
        unique case (r_state)
            S_RB: begin
                if (r_delay_whole == '0) begin
                    w_mac_a = r_x;
                end else begin
                    w_mac_a = r_rd_ok ? signed'(w_rdata) : '0;
                end
                w_mac_b = w_one_minus_frac;
            end
            S_RC: begin
                w_mac_a         = r_rd1_ok ? signed'(w_rdata) : '0;
                w_mac_b         = {1'b0, r_delay_fraction};
                w_mac_ctrl.load = 1'b1;
            end
            S_TAP: begin
                w_mac_ctrl.accum = 1'b1;
            end
            S_FB: begin
                w_mac_a = w_tap_now;
                w_mac_b = w_fb;
            end
            S_WR: begin
                w_mac_a = r_tap;
                w_mac_b = w_wet;
            end
            S_MIX1: begin
                w_mac_a         = r_x;
                w_mac_b         = w_dry;
                w_mac_ctrl.load = 1'b1;
            end
            S_MIX2: begin
                w_mac_ctrl.accum = 1'b1;
            end
            default: ;
        endcase
    end

    ffd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .i_ctrl  (w_mac_ctrl),
        .o_prod  (w_prod),
        .o_acc   (w_acc)
    );

    assign w_raddr = (r_state == S_RA) ? r_rd : r_rd1;
    assign w_we    = (r_state == S_WR);

    ffd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_stored),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: n_state = w_accept ? S_RA : S_IDLE;
            S_RA:   n_state = S_RB;
            S_RB:   n_state = S_RC;
            S_RC:   n_state = S_TAP;
            S_TAP:  n_state = S_FB;
            S_FB:   n_state = S_WR;
            S_WR:   n_state = S_MIX1;
            S_MIX1: n_state = S_MIX2;
            S_MIX2: n_state = S_OUT;
            S_OUT:  n_state = w_out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_wp <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
                if (r_wp == LAST_ADDR) begin
                    r_wrapped <= 1'b1;
                end
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Entries at or past the write position were never written until the
    // store has wrapped once, and they read as zero.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x      <= signed'(i_s_axis_tdata[SB-1:0]);
            r_rd     <= w_rd;
            r_rd1    <= w_rd1;
            r_rd_ok  <= r_wrapped || (w_rd < r_wp);
            r_rd1_ok <= r_wrapped || (w_rd1 < r_wp);
        end
        if (r_state == S_FB) begin
            r_tap <= w_tap_now;
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out <= w_mixed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDW'(unsigned'(r_out));

`ifndef SYNTHESIS
    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RA))
        else $error("accepted sample did not start the store read");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=>
            (r_wp == (($past(r_wp) == LAST_ADDR) ? '0 : $past(r_wp) + 1'b1)))
        else $error("write position did not advance after the store write");

    a_no_input_while_reducing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_red_busy |-> !o_s_axis_tready)
        else $error("input accepted while the delay reduction runs");

    a_wrapped_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrapped |=> r_wrapped)
        else $error("fill flag cleared outside reset");
`endif

endmodule
